/* design/scad_pkg.sv */
package scad_pkg;

	localparam int unsigned ADDR_BITS    = 16;
	localparam int unsigned ADDR_W       = 16;
	localparam int unsigned BLOCK_W      = 16;
	localparam int unsigned TAG_W        = 16;
	localparam int unsigned SETIDX_W     = 6;
	localparam int unsigned WAYIDX_W     = 3;
	localparam int unsigned AGE_W        = 3;
	localparam int unsigned OFF_W        = 4;
	localparam int unsigned SB_W         = 3;
	localparam int unsigned WAYS_CFG_W   = 4;
	localparam int unsigned PADDR_W      = 4;
	localparam int unsigned PDATA_W      = 32;
	localparam int unsigned MAX_SETS_DEF = 64;
	localparam int unsigned MAX_WAYS_DEF = 8;
	localparam int unsigned WAYS_LIMIT   = 8;

	localparam logic [AGE_W-1:0] AGE_MAX   = 3'd7;
	localparam logic [AGE_W:0]   AGE_EMPTY = 4'd8;
	localparam logic [OFF_W-1:0] OFF_LIMIT = 4'd8;
	localparam logic [SB_W-1:0]  SB_LIMIT  = 3'd6;

	localparam logic [ADDR_W-1:0] ADDR_MASK =
		(ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

	localparam logic [OFF_W-1:0]      RST_LINE_BYTES_LOG2 = 4'd2;
	localparam logic [SB_W-1:0]       RST_SET_COUNT_LOG2  = 3'd2;
	localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE     = 4'd2;

	typedef enum logic [1:0] {
		REG_LINE_BYTES_LOG2,
		REG_SET_COUNT_LOG2,
		REG_WAYS_IN_USE,
		REG_VICTIM_SEL
	} reg_idx_t;

	typedef enum logic {
		ACT_READ,
		ACT_WRITE
	} action_t;

	typedef enum logic {
		POL_LRU,
		POL_FIFO
	} policy_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [AGE_W-1:0] age;
		logic [TAG_W-1:0] tag;
	} line_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [SB_W-1:0]  sb;
	} layout_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] block;
		logic [TAG_W-1:0]   tag;
	} split_t;

endpackage

/* design/scad_if.sv */
interface scad_req_if import scad_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [ADDR_W-1:0] address;

	modport source (output valid, action, address, input ready);
	modport sink (input valid, action, address, output ready);
endinterface

interface scad_rsp_if import scad_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                hit;
	logic [SETIDX_W-1:0] set_index;
	logic [WAYIDX_W-1:0] way;
	logic [BLOCK_W-1:0]  block_number;
	logic                filled_empty;

	modport source (output valid, hit, set_index, way, block_number, filled_empty, input ready);
	modport sink (input valid, hit, set_index, way, block_number, filled_empty, output ready);
endinterface

/* design/scad_addr_split.sv */
module scad_addr_split import scad_pkg::*; #(
	parameter int unsigned MAX_SETS = MAX_SETS_DEF,
	localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  logic [ADDR_W-1:0] address,
	input  layout_t           layout,
	output split_t            split,
	output logic [SET_W-1:0]  set_idx
);

	localparam int unsigned RAW_N = 2 ** SETIDX_W;

	logic [ADDR_W-1:0]   addr_m;
	logic [SETIDX_W-1:0] raw_mask;
	logic [SETIDX_W-1:0] raw_set;
	logic [OFF_W:0]      tag_sh;
	logic [SET_W-1:0]    set_tab [RAW_N];

	assign addr_m      = address & ADDR_MASK;
	assign split.block = BLOCK_W'(addr_m >> layout.off);
	assign raw_mask    = SETIDX_W'(({1'b0, {SETIDX_W{1'b0}}} + 1'b1 << layout.sb) - 1'b1);
	assign raw_set     = split.block[SETIDX_W-1:0] & raw_mask;
	assign tag_sh      = (OFF_W+1)'(layout.off) + (OFF_W+1)'(layout.sb);
	assign split.tag   = TAG_W'(addr_m >> tag_sh);

	// wrap set numbers that lie beyond the directory depth
	for (genvar i = 0; i < RAW_N; i++) begin : g_set_tab
		localparam int unsigned Rem = i % MAX_SETS;
		assign set_tab[i] = SET_W'(Rem);
	end

	assign set_idx = set_tab[raw_set];

endmodule

/* design/set_assoc_cache_directory.sv */
// Tag directory of a set-associative cache with LRU or FIFO replacement.
// req (sink): one access per transfer, action (0 read, 1 write) and byte address.
// rsp (source): one result per access: hit, set_index, way, block_number and
// filled_empty (a miss that took an invalid way, nothing evicted).
// APB port: line_bytes_log2 at 0x0, set_count_log2 at 0x4, ways_in_use at 0x8,
// victim policy (0 LRU, 1 FIFO) at 0xC; write only while no access is in flight.
// pready is tied high.
// Timing: an access reads its set row from the directory memory at the accept edge,
// then one shared tag/age comparator walks the ways, one way per cycle, then the
// updated row is written back and the result is loaded into the output register.
// A new access is accepted only once the previous one has been written back and the
// sequencer is idle again.
// Reset: registers take their defaults and a per-set flag marks every row empty, so
// the directory reads as all invalid at once, with no clearing pass.
// Stall: a result waits in the output register; the block takes one more access,
// finishes its scan and holds it before write-back until the output register frees.
module set_assoc_cache_directory import scad_pkg::*; #(
	parameter int unsigned MAX_SETS = MAX_SETS_DEF,
	parameter int unsigned MAX_WAYS = MAX_WAYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	scad_req_if.sink           req,
	scad_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int unsigned SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int unsigned WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned WAYS_CAP  = (MAX_WAYS < WAYS_LIMIT) ? MAX_WAYS : WAYS_LIMIT;

	typedef line_t [MAX_WAYS-1:0] row_t;

	logic [OFF_W-1:0]      lbl_q;
	logic [SB_W-1:0]       scl_q;
	logic [WAYS_CFG_W-1:0] wiu_q;
	policy_t               pol_q;
	logic                  cfg_we;
	reg_idx_t              cfg_idx;

	layout_t               layout;
	logic [WAYS_CFG_W-1:0] ways_eff;
	logic [WAY_W-1:0]      last_way;
	split_t                split;
	logic [SET_W-1:0]      set_d;

	state_t                state_q;
	state_t                state_d;
	logic                  in_acc;
	logic                  scan_en;
	logic                  commit_go;

	row_t                  row_mem [MAX_SETS];
	row_t                  row_rd_q;
	row_t                  row_cur;
	row_t                  row_new;
	logic [MAX_SETS-1:0]   init_q;

	logic                  action_q;
	logic [BLOCK_W-1:0]    block_q;
	logic [TAG_W-1:0]      tag_q;
	logic [SET_W-1:0]      set_q;
	logic [WAY_W-1:0]      way_cnt_q;
	logic                  hit_found_q;
	logic [WAY_W-1:0]      hit_way_q;
	logic                  empty_found_q;
	logic [WAY_W-1:0]      empty_way_q;
	logic [AGE_W-1:0]      best_age_q;
	logic [WAY_W-1:0]      best_way_q;
	line_t                 lane;

	logic [WAY_W-1:0]      tgt_way;
	logic [AGE_W:0]        old_age;
	logic                  do_touch;

	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [SETIDX_W-1:0]   out_set_q;
	logic [WAYIDX_W-1:0]   out_way_q;
	logic [BLOCK_W-1:0]    out_block_q;
	logic                  out_empty_q;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbl_q <= RST_LINE_BYTES_LOG2;
			scl_q <= RST_SET_COUNT_LOG2;
			wiu_q <= RST_WAYS_IN_USE;
			pol_q <= POL_LRU;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LINE_BYTES_LOG2: lbl_q <= pwdata[OFF_W-1:0];
				REG_SET_COUNT_LOG2:  scl_q <= pwdata[SB_W-1:0];
				REG_WAYS_IN_USE:     wiu_q <= pwdata[WAYS_CFG_W-1:0];
				REG_VICTIM_SEL:      pol_q <= policy_t'(pwdata[0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_LINE_BYTES_LOG2: prdata = PDATA_W'(lbl_q);
			REG_SET_COUNT_LOG2:  prdata = PDATA_W'(scl_q);
			REG_WAYS_IN_USE:     prdata = PDATA_W'(wiu_q);
			REG_VICTIM_SEL:      prdata = PDATA_W'(pol_q);
			default:             prdata = '0;
		endcase
	end

	// effective layout
	assign layout.off = (lbl_q > OFF_LIMIT) ? OFF_LIMIT : lbl_q;
	assign layout.sb  = (scl_q > SB_LIMIT) ? SB_LIMIT : scl_q;

	always_comb begin
		if (wiu_q == '0) begin
			ways_eff = WAYS_CFG_W'(1);
		end else if (wiu_q > WAYS_CFG_W'(WAYS_CAP)) begin
			ways_eff = WAYS_CFG_W'(WAYS_CAP);
		end else begin
			ways_eff = wiu_q;
		end
	end

	assign last_way = WAY_W'(ways_eff - 1'b1);

	scad_addr_split #(
		.MAX_SETS (MAX_SETS)
	) u_split (
		.address (req.address),
		.layout  (layout),
		.split   (split),
		.set_idx (set_d)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		scan_en   = 1'b0;
		commit_go = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				scan_en = 1'b1;
				if (way_cnt_q == last_way) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				commit_go = !out_valid_q || rsp.ready;
				if (commit_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_acc = req.valid && req.ready;

	// directory memory, one row per set
	always_ff @(posedge clk) begin
		if (in_acc) row_rd_q <= row_mem[set_d];
		if (commit_go) row_mem[set_q] <= row_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
		end else if (commit_go) begin
			init_q[set_q] <= 1'b1;
		end
	end

	assign row_cur = init_q[set_q] ? row_rd_q : '0;
	assign lane    = row_cur[way_cnt_q];

	// scan one way per cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q      <= req.action;
			block_q       <= split.block;
			tag_q         <= split.tag;
			set_q         <= set_d;
			way_cnt_q     <= '0;
			hit_found_q   <= 1'b0;
			hit_way_q     <= '0;
			empty_found_q <= 1'b0;
			empty_way_q   <= '0;
			best_age_q    <= '0;
			best_way_q    <= '0;
		end else if (scan_en) begin
			way_cnt_q <= WAY_W'(way_cnt_q + 1'b1);
			if (!hit_found_q && lane.valid && (lane.tag == tag_q)) begin
				hit_found_q <= 1'b1;
				hit_way_q   <= way_cnt_q;
			end
			if (!empty_found_q && !lane.valid) begin
				empty_found_q <= 1'b1;
				empty_way_q   <= way_cnt_q;
			end
			if (lane.age > best_age_q) begin
				best_age_q <= lane.age;
				best_way_q <= way_cnt_q;
			end
		end
	end

	// replacement and age update
	always_comb begin
		priority if (hit_found_q) begin
			tgt_way = hit_way_q;
			old_age = {1'b0, row_cur[hit_way_q].age};
		end else if (empty_found_q) begin
			tgt_way = empty_way_q;
			old_age = AGE_EMPTY;
		end else begin
			tgt_way = best_way_q;
			old_age = {1'b0, best_age_q};
		end
	end

	assign do_touch = !hit_found_q || (pol_q == POL_LRU);

	always_comb begin
		row_new = row_cur;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_W'(w) == tgt_way) begin
				if (do_touch) row_new[w].age = '0;
				if (!hit_found_q) begin
					row_new[w].valid = 1'b1;
					row_new[w].dirty = (action_q == ACT_WRITE);
					row_new[w].tag   = tag_q;
				end else if (action_q == ACT_WRITE) begin
					row_new[w].dirty = 1'b1;
				end
			end else if (do_touch && (WAYS_CFG_W'(w) < ways_eff) && row_cur[w].valid &&
					({1'b0, row_cur[w].age} < old_age) && (row_cur[w].age != AGE_MAX)) begin
				row_new[w].age = AGE_W'(row_cur[w].age + 1'b1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			out_hit_q   <= hit_found_q;
			out_set_q   <= SETIDX_W'(set_q);
			out_way_q   <= WAYIDX_W'(tgt_way);
			out_block_q <= block_q;
			out_empty_q <= !hit_found_q && empty_found_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.hit          = out_hit_q;
	assign rsp.set_index    = out_set_q;
	assign rsp.way          = out_way_q;
	assign rsp.block_number = out_block_q;
	assign rsp.filled_empty = out_empty_q;

endmodule

/* design/scad_checker.sv */
module scad_checker import scad_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic                hit,
	input logic [SETIDX_W-1:0] set_index,
	input logic [WAYIDX_W-1:0] way,
	input logic [BLOCK_W-1:0]  block_number,
	input logic                filled_empty
);

	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("access accepted while previous one in flight");

	a_no_result_at_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_xfer))
		else $error("result appeared right after an accept");

	a_hit_not_filled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && filled_empty))
		else $error("hit reported as empty fill");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(set_index) &&
			$stable(way) && $stable(block_number) && $stable(filled_empty))
		else $error("stalled result changed");

endmodule

bind set_assoc_cache_directory scad_checker u_scad_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.hit          (rsp.hit),
	.set_index    (rsp.set_index),
	.way          (rsp.way),
	.block_number (rsp.block_number),
	.filled_empty (rsp.filled_empty)
);
